// File: hdl/rhc_pkg.sv
package rhc_pkg;

    localparam int CH_W  = 8;
    localparam int NUM_W = 16;
    localparam int Q_W   = 8;

    localparam logic [CH_W-1:0] HUE_STEP   = 8'd43;
    localparam logic [CH_W-1:0] BASE_RED   = 8'd0;
    localparam logic [CH_W-1:0] BASE_GREEN = 8'd85;
    localparam logic [CH_W-1:0] BASE_BLUE  = 8'd171;
    localparam logic [CH_W-1:0] FULL_SCALE = 8'd255;

    // Work carried along the divider chain. Two restoring divisions run side by
    // side: saturation (255*spread / max) and hue offset (43*|diff| / spread).
    typedef struct packed {
        logic [NUM_W-1:0] rem_s;
        logic [NUM_W-1:0] rem_h;
        logic [CH_W-1:0]  div_s;
        logic [CH_W-1:0]  div_h;
        logic [Q_W-1:0]   q_s;
        logic [Q_W-1:0]   q_h;
        logic [CH_W-1:0]  base;
        logic             neg;
        logic [CH_W-1:0]  hi;
    } t_cell;

endpackage

// File: hdl/rgb_to_hsv_converter_unit.sv
// RGB to HSV converter, 8 bits per channel.
//
// Slave channel: one RGB pixel per transaction on s_tdata. Master channel:
// one HSV pixel per transaction on m_tdata. Each input transaction yields
// exactly one output transaction, in order.
//
// A pixel passes 10 register stages: one for max/min and the two numerators
// (loaded at the accepting edge), eight cells of a restoring divider that
// each settle one quotient bit of both divisions, and one output register
// that applies the base and the black/gray cases.
// Throughput is one pixel per cycle unless the receiver stalls; every stage
// has its own valid bit, so a pixel is taken while others are in the divider chain.
//
// Reset (synchronous, active low) empties every stage; nothing is in flight
// afterwards. When the receiver stalls, the held result stays on m_tdata,
// bubbles in the chain fill up, and s_tready drops only once all stages
// hold data.
module rgb_to_hsv_converter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // hue [7:0], saturation [15:8], brightness [23:16]
);
    import rhc_pkg::*;

    localparam int NCELL = Q_W;

    logic  chain_valid [NCELL+1];
    logic  chain_ready [NCELL+1];
    t_cell chain_data  [NCELL+1];

    logic            r_out_valid;
    logic [23:0]     r_out_data;
    logic            out_ready;
    t_cell           last;
    logic [CH_W-1:0] n_hue;
    logic [CH_W-1:0] n_sat;

    rhc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_red   (s_tdata[7:0]),
        .i_green (s_tdata[15:8]),
        .i_blue  (s_tdata[23:16]),
        .o_valid (chain_valid[0]),
        .i_ready (chain_ready[0]),
        .o_data  (chain_data[0])
    );

    // Cell k settles quotient bit NCELL-1-k, most significant first.
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        rhc_div_cell #(
            .K (NCELL - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[k]),
            .o_ready (chain_ready[k]),
            .i_data  (chain_data[k]),
            .o_valid (chain_valid[k+1]),
            .i_ready (chain_ready[k+1]),
            .o_data  (chain_data[k+1])
        );
    end

    assign out_ready          = !r_out_valid || m_tready;
    assign chain_ready[NCELL] = out_ready;
    assign last               = chain_data[NCELL];

    // A black pixel divides by zero; its quotients are discarded here. A zero
    // saturation (gray pixel) forces the hue to zero as well.
    always_comb begin
        if (last.hi == '0) begin
            n_sat = '0;
            n_hue = '0;
        end else begin
            n_sat = last.q_s;
            if (last.q_s == '0) begin
                n_hue = '0;
            end else if (last.neg) begin
                n_hue = last.base - last.q_h;
            end else begin
                n_hue = last.base + last.q_h;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= chain_valid[NCELL];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && chain_valid[NCELL]) begin
            r_out_data <= {last.hi, n_sat, n_hue};
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

endmodule

// File: hdl/rhc_front.sv
module rhc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_red,
    input  logic [7:0]          i_green,
    input  logic [7:0]          i_blue,
    output logic                o_valid,
    input  logic                i_ready,
    output rhc_pkg::t_cell      o_data
);
    import rhc_pkg::*;

    logic            r_valid;
    t_cell           r_data;
    t_cell           n_data;
    logic [CH_W-1:0] hi;
    logic [CH_W-1:0] lo;
    logic [CH_W-1:0] spread;
    logic [CH_W:0]   diff;
    logic [CH_W-1:0] mag;
    logic [13:0]     num_h;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        hi = i_red;
        if (i_green > hi) hi = i_green;
        if (i_blue > hi) hi = i_blue;
        lo = i_red;
        if (i_green < lo) lo = i_green;
        if (i_blue < lo) lo = i_blue;
        spread = hi - lo;

        // Red wins ties over green, green over blue.
        if (hi == i_red) begin
            diff        = {1'b0, i_green} - {1'b0, i_blue};
            n_data.base = BASE_RED;
        end else if (hi == i_green) begin
            diff        = {1'b0, i_blue} - {1'b0, i_red};
            n_data.base = BASE_GREEN;
        end else begin
            diff        = {1'b0, i_red} - {1'b0, i_green};
            n_data.base = BASE_BLUE;
        end
        mag   = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];
        num_h = 14'(mag) * 14'(HUE_STEP);

        n_data.rem_s = NUM_W'(spread) * NUM_W'(FULL_SCALE);
        n_data.rem_h = {2'b00, num_h};
        n_data.div_s = hi;
        n_data.div_h = spread;
        n_data.q_s   = '0;
        n_data.q_h   = '0;
        n_data.neg   = diff[CH_W];
        n_data.hi    = hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// File: hdl/rhc_div_cell.sv
module rhc_div_cell #(
    parameter int K = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rhc_pkg::t_cell i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output rhc_pkg::t_cell o_data
);
    import rhc_pkg::*;

    logic             r_valid;
    t_cell            r_data;
    t_cell            n_data;
    logic [NUM_W-1:0] sh_s;
    logic [NUM_W-1:0] sh_h;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // One quotient bit per cell for each of the two divisions.
    always_comb begin
        n_data = i_data;
        sh_s   = NUM_W'({{(NUM_W-CH_W){1'b0}}, i_data.div_s} << K);
        sh_h   = NUM_W'({{(NUM_W-CH_W){1'b0}}, i_data.div_h} << K);
        if (i_data.rem_s >= sh_s) begin
            n_data.rem_s  = i_data.rem_s - sh_s;
            n_data.q_s[K] = 1'b1;
        end
        if (i_data.rem_h >= sh_h) begin
            n_data.rem_h  = i_data.rem_h - sh_h;
            n_data.q_h[K] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// File: hdl/rhc_checker.sv
module rhc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // A stalled result must hold.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Black pixel has zero hue and zero saturation.
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[23:16] == 8'd0 |-> m_tdata[15:0] == 16'd0)
        else $error("black pixel with nonzero hue or saturation");

    // Zero saturation means zero hue.
    a_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[15:8] == 8'd0 |-> m_tdata[7:0] == 8'd0)
        else $error("unsaturated pixel with nonzero hue");

    // Reset empties the pipeline; no stale result follows it.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid right after reset");

    // Nothing can come out within the pipeline latency after reset.
    a_nofast: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_tvalid) [*10])
        else $error("result appeared faster than the pipeline allows");

endmodule

bind rgb_to_hsv_converter_unit rhc_checker u_rhc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
